// ===== rtl/core/isrt_pkg.sv =====
// shared types and constants for the insertion sort engine
// no dependencies; used by isrt_cell and insertion_sort_engine_top
package isrt_pkg;

  localparam int unsigned MAX_ITEMS = 64;

  typedef struct packed {
    logic signed [31:0] value_in;
    logic               last_in;
  } item_t;

  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               last_out;
    logic               overflow;
  } result_t;

  typedef enum logic [0:0] {
    ST_FILL,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic insert;
    logic shift_down;
    logic descending;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/isrt_cell.sv =====
// one cell of the sorting chain: holds one entry and its occupied flag
// depends on isrt_pkg for the control struct
module isrt_cell (
  input  logic                clk,
  input  logic                rst,
  input  isrt_pkg::cell_ctrl_t ctrl,
  input  logic signed [31:0]  key,
  input  logic signed [31:0]  below_value,
  input  logic                below_occ,
  input  logic signed [31:0]  above_value,
  input  logic                above_occ,
  input  logic                sfx_self,
  input  logic                sfx_below,
  output logic signed [31:0]  value,
  output logic                occ,
  output logic                moves
);

  logic goes_after;

  // stored entry must pass the new key; an empty cell always yields
  always_comb begin
    if (ctrl.descending) begin
      goes_after = key > value;
    end else begin
      goes_after = value > key;
    end
    moves = goes_after || !occ;
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift_down) begin
      value <= above_value;
    end else if (ctrl.insert) begin
      if (sfx_below) begin
        value <= below_value;
      end else if (sfx_self) begin
        value <= key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (ctrl.shift_down) begin
      occ <= above_occ;
    end else if (ctrl.insert) begin
      if (sfx_below) begin
        occ <= below_occ;
      end else if (sfx_self) begin
        occ <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/insertion_sort_engine_top.sv =====
// top level of the insertion sort engine: chain of isrt_cell, control, result register
// depends on isrt_pkg and isrt_cell
//
// channel  | handshake                   | payload
// ---------+-----------------------------+-----------------------------
// item     | item_valid / item_stall     | item   (value_in, last_in)
// result   | result_valid / result_stall | result (sorted_value, last_out, overflow)
// config   | wr_en                       | wr_data (sort_descending)
//
// an item beat is inserted when accepted unless the chain is full; beats can arrive every cycle in ST_FILL
// after a last beat the set of n entries drains from cell 0, one beat per cycle while
// result_stall allows; item_stall stays high for the whole drain, result stalls included
// rst is synchronous; it empties the chain and clears the overflow flag
// the result register holds its beat while result_stall is high
module insertion_sort_engine_top #(
  parameter int unsigned MAX_ITEMS = isrt_pkg::MAX_ITEMS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  isrt_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output isrt_pkg::result_t result,
  input  logic              wr_en,
  input  logic              wr_data
);

  isrt_pkg::state_t     state, state_next;
  isrt_pkg::cell_ctrl_t ctrl;
  logic                 descending;
  logic                 overflow_seen;
  logic                 accept;
  logic                 full;
  logic                 take;

  logic signed [31:0]   value [MAX_ITEMS];
  logic [MAX_ITEMS-1:0] occ;
  logic [MAX_ITEMS-1:0] moves;
  logic [MAX_ITEMS-1:0] sfx;

  assign full   = occ[MAX_ITEMS-1];
  assign accept = item_valid && !item_stall;
  assign take   = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      descending <= 1'b0;
    end else if (wr_en) begin
      descending <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= isrt_pkg::ST_FILL;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    item_stall      = 1'b1;
    ctrl.insert     = 1'b0;
    ctrl.shift_down = 1'b0;
    ctrl.descending = descending;
    case (state)
      isrt_pkg::ST_FILL: begin
        item_stall  = 1'b0;
        ctrl.insert = accept && !full;
        if (accept && item.last_in) begin
          state_next = isrt_pkg::ST_DRAIN;
        end
      end
      isrt_pkg::ST_DRAIN: begin
        ctrl.shift_down = take;
        if (take && !occ[1]) begin
          state_next = isrt_pkg::ST_FILL;
        end
      end
      default: begin
        state_next = isrt_pkg::ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      overflow_seen <= 1'b0;
    end else if (accept && full) begin
      overflow_seen <= 1'b1;
    end else if (ctrl.shift_down && !occ[1]) begin
      overflow_seen <= 1'b0;
    end
  end

  // an entry moves when it and every entry above it pass the key
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_sfx
    assign sfx[i] = &moves[MAX_ITEMS-1:i];
  end

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic signed [31:0] below_value;
    logic               below_occ;
    logic               sfx_below;
    logic signed [31:0] above_value;
    logic               above_occ;

    if (i == 0) begin : g_first
      assign below_value = '0;
      assign below_occ   = 1'b1;
      assign sfx_below   = 1'b0;
    end else begin : g_inner
      assign below_value = value[i-1];
      assign below_occ   = occ[i-1];
      assign sfx_below   = sfx[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_last
      assign above_value = '0;
      assign above_occ   = 1'b0;
    end else begin : g_mid
      assign above_value = value[i+1];
      assign above_occ   = occ[i+1];
    end

    isrt_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .key         (item.value_in),
      .below_value (below_value),
      .below_occ   (below_occ),
      .above_value (above_value),
      .above_occ   (above_occ),
      .sfx_self    (sfx[i]),
      .sfx_below   (sfx_below),
      .value       (value[i]),
      .occ         (occ[i]),
      .moves       (moves[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctrl.shift_down) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift_down) begin
      result.sorted_value <= value[0];
      result.last_out     <= !occ[1];
      result.overflow     <= overflow_seen || (accept && full);
    end
  end

  // occupied cells always form a contiguous run from cell 0
  a_occ_run: assert property (@(posedge clk) disable iff (rst)
    ((occ >> 1) & ~occ) == '0)
    else $error("occupied cells not contiguous");

  // the chain is never empty while draining
  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == isrt_pkg::ST_DRAIN) |-> occ[0])
    else $error("draining an empty chain");

  // the final beat of a set leaves the chain empty
  a_drain_empties: assert property (@(posedge clk) disable iff (rst)
    (ctrl.shift_down && !occ[1]) |=> (occ == '0 && !overflow_seen))
    else $error("chain not empty after final beat");

  // a new beat is only produced while draining
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !$past(result_valid && result_stall))
      |-> $past(state == isrt_pkg::ST_DRAIN))
    else $error("result beat outside drain");

endmodule
